### sv/encoder_distance_move_controller_assert.svh
// Assertion macros shared by the checker.
`ifndef ENCODER_DISTANCE_MOVE_CONTROLLER_ASSERT_SVH
`define ENCODER_DISTANCE_MOVE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define EDM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("encoder move controller: check failed");

// Next-cycle implication, masked during reset.
`define EDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("encoder move controller: check failed");

`endif

### sv/edm_pkg.sv
package edm_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int DUTY_MAX    = 255;
    localparam int DUTY_W      = $clog2(DUTY_MAX + 1);
    localparam int OUT_DUTY_W  = 8;
    localparam int AVG_W       = 31;
    localparam int DIST_W      = 16;
    localparam int GAIN_W      = 10;
    localparam int ERR_ABS_W   = DIST_W;            // |left - right| fits 16 bits
    localparam int PROD_W      = ERR_ABS_W + GAIN_W;
    localparam int GAIN_SHIFT  = 12;                // 1/16 mm and Q8 gain
    localparam int MAG_W       = PROD_W - GAIN_SHIFT;
    localparam int CORR_W      = MAG_W + 3;         // signed duty arithmetic
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;

    localparam logic [31:0] BRAKE_HOLD_MS = 32'd100;

    // phase codes
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_MOVING  = 2'd1;
    localparam logic [1:0] PH_BRAKING = 2'd2;

    // status codes
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MOVING   = 3'd1;
    localparam logic [2:0] ST_BRAKING  = 3'd2;
    localparam logic [2:0] ST_REACHED  = 3'd3;
    localparam logic [2:0] ST_STOPPED  = 3'd4;
    localparam logic [2:0] ST_STALLED  = 3'd5;
    localparam logic [2:0] ST_OBSTACLE = 3'd6;

    // item opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_PWM      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_PULSES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUMP_DISTANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_WINDOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CORR   = 3'd6;

    // register reset values
    localparam logic [15:0]       RST_STALL_TIMEOUT = 16'd300;
    localparam logic [14:0]       RST_BUMP_DISTANCE = 15'd448;
    localparam logic [14:0]       RST_WALL_WINDOW   = 15'd1920;
    localparam logic [GAIN_W-1:0] RST_CENTER_GAIN   = 10'd154;

    typedef struct packed {
        logic [7:0]        base_pwm;
        logic [AVG_W-1:0]  target_pulses;
        logic [15:0]       stall_timeout_ms;
        logic [14:0]       bump_distance;
        logic [14:0]       wall_window;
        logic [GAIN_W-1:0] centering_gain;
        logic              ignore_correction;
    } cfg_t;

    typedef struct packed {
        logic                     op;
        logic [31:0]              now_ms;
        logic [AVG_W-1:0]         avg;
        logic signed [DIST_W-1:0] front_dist;
        logic signed [DIST_W-1:0] left_dist;
        logic signed [DIST_W-1:0] right_dist;
        logic                     stop_request;
        logic                     err_neg;
        logic [MAG_W-1:0]         corr_mag;
    } item_t;

    typedef struct packed {
        logic [OUT_DUTY_W-1:0] right_a_duty;
        logic [OUT_DUTY_W-1:0] right_b_duty;
        logic [OUT_DUTY_W-1:0] left_a_duty;
        logic [OUT_DUTY_W-1:0] left_b_duty;
        logic [2:0]            status;
        logic [AVG_W-1:0]      average_count;
    } result_t;

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [CORR_W-1:0] v);
        logic [DUTY_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed(CORR_W'(DUTY_MAX))) begin
            r = DUTY_W'(DUTY_MAX);
        end else begin
            r = v[DUTY_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/edm_prep.sv
module edm_prep
    import edm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_op,
    input  logic [31:0]              s_now_ms,
    input  logic signed [31:0]       s_left_count,
    input  logic signed [31:0]       s_right_count,
    input  logic signed [DIST_W-1:0] s_front_dist,
    input  logic signed [DIST_W-1:0] s_left_dist,
    input  logic signed [DIST_W-1:0] s_right_dist,
    input  logic                     s_stop_request,
    input  logic [GAIN_W-1:0]        centering_gain,
    input  logic                     take,
    output logic                     item_valid,
    output item_t                    item
);

    logic                    valid_reg;
    item_t                   item_reg;
    item_t                   item_next;

    logic [COUNT_WIDTH-1:0]  lc;
    logic [COUNT_WIDTH-1:0]  rc;
    logic [COUNT_WIDTH-1:0]  abs_l;
    logic [COUNT_WIDTH-1:0]  abs_r;
    logic [COUNT_WIDTH:0]    sum;
    logic [31:0]             half32;
    logic signed [DIST_W:0]  err;
    logic [DIST_W:0]         err_abs;
    logic [PROD_W-1:0]       prod;

    assign s_ready = !valid_reg || take;

    always_comb begin
        lc      = s_left_count[COUNT_WIDTH-1:0];
        rc      = s_right_count[COUNT_WIDTH-1:0];
        abs_l   = lc[COUNT_WIDTH-1] ? (~lc) + COUNT_WIDTH'(1) : lc;
        abs_r   = rc[COUNT_WIDTH-1] ? (~rc) + COUNT_WIDTH'(1) : rc;
        sum     = {1'b0, abs_l} + {1'b0, abs_r};
        half32  = 32'(sum[COUNT_WIDTH:1]);

        err     = {s_left_dist[DIST_W-1], s_left_dist} - {s_right_dist[DIST_W-1], s_right_dist};
        err_abs = err[DIST_W] ? (~err) + (DIST_W+1)'(1) : err;
        prod    = err_abs[ERR_ABS_W-1:0] * centering_gain;

        item_next.op           = s_op;
        item_next.now_ms       = s_now_ms;
        item_next.avg          = half32[31] ? {AVG_W{1'b1}} : half32[AVG_W-1:0];
        item_next.front_dist   = s_front_dist;
        item_next.left_dist    = s_left_dist;
        item_next.right_dist   = s_right_dist;
        item_next.stop_request = s_stop_request;
        item_next.err_neg      = err[DIST_W];
        item_next.corr_mag     = prod[PROD_W-1:GAIN_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/edm_ctrl.sv
module edm_ctrl
    import edm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    item_valid,
    input  item_t   item,
    output logic    take,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t result
);

    logic [1:0]        phase_reg,      phase_next;
    logic [AVG_W-1:0]  prev_avg_reg,   prev_avg_next;
    logic [31:0]       last_motion_reg, last_motion_next;
    logic [31:0]       brake_start_reg, brake_start_next;
    logic              m_valid_reg;
    result_t           res_reg,        res_next;

    logic [DUTY_W-1:0] ra, rb, la, lb;
    logic [2:0]        st;
    logic [2:0]        endst;
    logic [31:0]       since_brake;
    logic [31:0]       since_motion;
    logic              rose;
    logic              near_front;
    logic              side_ok;
    logic signed [CORR_W-1:0] adj_mag;
    logic signed [CORR_W-1:0] adj;
    logic signed [CORR_W-1:0] base_s;
    logic [DUTY_W-1:0] r_corr;
    logic [DUTY_W-1:0] l_corr;
    logic [DUTY_W-1:0] base_d;

    assign take = item_valid && (!m_valid_reg || m_ready);

    always_comb begin
        since_brake  = item.now_ms - brake_start_reg;
        since_motion = item.now_ms - last_motion_reg;
        rose         = item.avg > prev_avg_reg;
        // distances count only when strictly positive
        near_front   = !item.front_dist[DIST_W-1] && (item.front_dist != '0) &&
                       (item.front_dist[14:0] < cfg.bump_distance);
        side_ok      = !cfg.ignore_correction &&
                       !item.left_dist[DIST_W-1] && (item.left_dist != '0) &&
                       (item.left_dist[14:0] < cfg.wall_window) &&
                       !item.right_dist[DIST_W-1] && (item.right_dist != '0) &&
                       (item.right_dist[14:0] < cfg.wall_window);

        adj_mag = CORR_W'(item.corr_mag);
        adj     = item.err_neg ? -adj_mag : adj_mag;
        base_s  = CORR_W'(cfg.base_pwm);
        r_corr  = clamp_duty(base_s + adj);
        l_corr  = clamp_duty(base_s - adj);
        base_d  = DUTY_W'(cfg.base_pwm);
    end

    always_comb begin
        phase_next       = phase_reg;
        prev_avg_next    = prev_avg_reg;
        last_motion_next = last_motion_reg;
        brake_start_next = brake_start_reg;
        ra    = '0;
        rb    = '0;
        la    = '0;
        lb    = '0;
        st    = ST_IDLE;
        endst = ST_IDLE;

        case (phase_reg)
            PH_MOVING: begin
                if (item.op == OP_START) begin
                    rb = base_d;
                    la = base_d;
                    st = ST_MOVING;
                end else begin
                    if (item.stop_request) begin
                        endst = ST_STOPPED;
                    end else begin
                        if (rose) begin
                            last_motion_next = item.now_ms;
                            prev_avg_next    = item.avg;
                        end else if (since_motion > 32'(cfg.stall_timeout_ms)) begin
                            endst = ST_STALLED;
                        end
                        if (endst == ST_IDLE && item.avg >= cfg.target_pulses) begin
                            endst = ST_REACHED;
                        end
                        if (endst == ST_IDLE && near_front) begin
                            endst = ST_OBSTACLE;
                        end
                    end

                    if (endst != ST_IDLE) begin
                        phase_next       = PH_BRAKING;
                        brake_start_next = item.now_ms;
                        ra = DUTY_W'(DUTY_MAX);
                        rb = DUTY_W'(DUTY_MAX);
                        la = DUTY_W'(DUTY_MAX);
                        lb = DUTY_W'(DUTY_MAX);
                        st = endst;
                    end else if (side_ok) begin
                        rb = r_corr;
                        la = l_corr;
                        st = ST_MOVING;
                    end else begin
                        rb = base_d;
                        la = base_d;
                        st = ST_MOVING;
                    end
                end
            end
            PH_BRAKING: begin
                if (item.op == OP_TICK && since_brake >= BRAKE_HOLD_MS) begin
                    phase_next = PH_IDLE;
                end else begin
                    ra = DUTY_W'(DUTY_MAX);
                    rb = DUTY_W'(DUTY_MAX);
                    la = DUTY_W'(DUTY_MAX);
                    lb = DUTY_W'(DUTY_MAX);
                    st = ST_BRAKING;
                end
            end
            default: begin
                // idle, and the unused code behaves as idle
                phase_next = PH_IDLE;
                if (item.op == OP_START) begin
                    phase_next       = PH_MOVING;
                    prev_avg_next    = '0;
                    last_motion_next = item.now_ms;
                    rb = base_d;
                    la = base_d;
                    st = ST_MOVING;
                end
            end
        endcase

        res_next.right_a_duty  = OUT_DUTY_W'(ra);
        res_next.right_b_duty  = OUT_DUTY_W'(rb);
        res_next.left_a_duty   = OUT_DUTY_W'(la);
        res_next.left_b_duty   = OUT_DUTY_W'(lb);
        res_next.status        = st;
        res_next.average_count = item.avg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            prev_avg_reg    <= '0;
            last_motion_reg <= '0;
            brake_start_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (take) begin
                phase_reg       <= phase_next;
                prev_avg_reg    <= prev_avg_next;
                last_motion_reg <= last_motion_next;
                brake_start_reg <= brake_start_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = res_reg;

endmodule

### sv/encoder_distance_move_controller.sv
// A result passes the input register, then the result register, after its input
// transfer; one item is taken every cycle when results drain.
// Throughput: 1 item/cycle when results drain; the multiply sits before the input register, the compares after it.
// Reset (aresetn low, synchronous): phase idle, timers and previous average cleared,
// registers at defaults (timeout 300, bump 448, window 1920, gain 154).
module encoder_distance_move_controller
    import edm_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [31:0]                 s_now_ms,
    input  logic signed [31:0]          s_left_count,
    input  logic signed [31:0]          s_right_count,
    input  logic signed [DIST_W-1:0]    s_front_dist,
    input  logic signed [DIST_W-1:0]    s_left_dist,
    input  logic signed [DIST_W-1:0]    s_right_dist,
    input  logic                        s_stop_request,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [OUT_DUTY_W-1:0]       m_right_a_duty,
    output logic [OUT_DUTY_W-1:0]       m_right_b_duty,
    output logic [OUT_DUTY_W-1:0]       m_left_a_duty,
    output logic [OUT_DUTY_W-1:0]       m_left_b_duty,
    output logic [2:0]                  m_status,
    output logic [AVG_W-1:0]            m_average_count
);

    cfg_t    cfg_reg;
    logic    take;
    logic    item_valid;
    item_t   item;
    result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_pwm          <= '0;
            cfg_reg.target_pulses     <= '0;
            cfg_reg.stall_timeout_ms  <= RST_STALL_TIMEOUT;
            cfg_reg.bump_distance     <= RST_BUMP_DISTANCE;
            cfg_reg.wall_window       <= RST_WALL_WINDOW;
            cfg_reg.centering_gain    <= RST_CENTER_GAIN;
            cfg_reg.ignore_correction <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BASE_PWM:      cfg_reg.base_pwm          <= cfg_data[7:0];
                REG_TARGET_PULSES: cfg_reg.target_pulses     <= cfg_data[AVG_W-1:0];
                REG_STALL_TIMEOUT: cfg_reg.stall_timeout_ms  <= cfg_data[15:0];
                REG_BUMP_DISTANCE: cfg_reg.bump_distance     <= cfg_data[14:0];
                REG_WALL_WINDOW:   cfg_reg.wall_window       <= cfg_data[14:0];
                REG_CENTER_GAIN:   cfg_reg.centering_gain    <= cfg_data[GAIN_W-1:0];
                REG_IGNORE_CORR:   cfg_reg.ignore_correction <= cfg_data[0];
                default: ;
            endcase
        end
    end

    edm_prep u_prep (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_now_ms       (s_now_ms),
        .s_left_count   (s_left_count),
        .s_right_count  (s_right_count),
        .s_front_dist   (s_front_dist),
        .s_left_dist    (s_left_dist),
        .s_right_dist   (s_right_dist),
        .s_stop_request (s_stop_request),
        .centering_gain (cfg_reg.centering_gain),
        .take           (take),
        .item_valid     (item_valid),
        .item           (item)
    );

    edm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    assign m_right_a_duty  = result.right_a_duty;
    assign m_right_b_duty  = result.right_b_duty;
    assign m_left_a_duty   = result.left_a_duty;
    assign m_left_b_duty   = result.left_b_duty;
    assign m_status        = result.status;
    assign m_average_count = result.average_count;

endmodule

### sv/edm_checker.sv
`include "encoder_distance_move_controller_assert.svh"

module edm_checker
    import edm_pkg::*;
(
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [OUT_DUTY_W-1:0]       m_right_a_duty,
    input logic [OUT_DUTY_W-1:0]       m_right_b_duty,
    input logic [OUT_DUTY_W-1:0]       m_left_a_duty,
    input logic [OUT_DUTY_W-1:0]       m_left_b_duty,
    input logic [2:0]                  m_status,
    input logic [AVG_W-1:0]            m_average_count
);

    // a stalled result transfer keeps its status, average count and forward duties
    `EDM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_average_count) && $stable(m_right_b_duty) && $stable(m_left_a_duty))

    // any end of move and the hold that follows drive the brake pattern
    `EDM_ASSERT_IMPL(a_brake_pattern, m_valid && m_status >= ST_BRAKING, m_right_a_duty == OUT_DUTY_W'(DUTY_MAX) && m_right_b_duty == OUT_DUTY_W'(DUTY_MAX) && m_left_a_duty == OUT_DUTY_W'(DUTY_MAX) && m_left_b_duty == OUT_DUTY_W'(DUTY_MAX))

    // forward drive never energizes the reverse inputs
    `EDM_ASSERT_IMPL(a_forward_only, m_valid && m_status == ST_MOVING, m_right_a_duty == '0 && m_left_b_duty == '0)

    // idle means standby
    `EDM_ASSERT_IMPL(a_idle_standby, m_valid && m_status == ST_IDLE, m_right_a_duty == '0 && m_right_b_duty == '0 && m_left_a_duty == '0 && m_left_b_duty == '0)

endmodule

bind encoder_distance_move_controller edm_checker u_edm_checker (.*);

### tb/sv/tb_encoder_distance_move_controller.sv
`timescale 1ns / 1ps

module tb_encoder_distance_move_controller;
    import edm_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam logic [30:0] AVG_LIMIT = 31'h7FFF_FFFF;
    localparam logic signed [31:0] COUNT_MAX = 32'sd2147483647;

    typedef struct packed {
        logic               op;
        logic [31:0]        now_ms;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic signed [15:0] front_dist;
        logic signed [15:0] left_dist;
        logic signed [15:0] right_dist;
        logic               stop_request;
    } move_cmd_t;

    // Mirrors the controller: registers, move phase, stall and brake timers.
    class move_scoreboard;
        logic [7:0]  base_pwm;
        logic [30:0] target_pulses;
        logic [15:0] stall_timeout_ms;
        logic [14:0] bump_distance;
        logic [14:0] wall_window;
        logic [9:0]  centering_gain;
        logic        ignore_correction;
        logic [1:0]  phase;
        logic [31:0] prev_avg;
        logic [31:0] last_motion_ms;
        logic [31:0] brake_start_ms;
        result_t     pending_outputs[$];
        int          errors;
        int          outputs_seen;

        function new();
            base_pwm          = '0;
            target_pulses     = '0;
            stall_timeout_ms  = RST_STALL_TIMEOUT;
            bump_distance     = RST_BUMP_DISTANCE;
            wall_window       = RST_WALL_WINDOW;
            centering_gain    = RST_CENTER_GAIN;
            ignore_correction = 1'b0;
            phase             = PH_IDLE;
            prev_avg          = '0;
            last_motion_ms    = '0;
            brake_start_ms    = '0;
            errors            = 0;
            outputs_seen      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BASE_PWM:      base_pwm          = data[7:0];
                REG_TARGET_PULSES: target_pulses     = data[30:0];
                REG_STALL_TIMEOUT: stall_timeout_ms  = data[15:0];
                REG_BUMP_DISTANCE: bump_distance     = data[14:0];
                REG_WALL_WINDOW:   wall_window       = data[14:0];
                REG_CENTER_GAIN:   centering_gain    = data[9:0];
                REG_IGNORE_CORR:   ignore_correction = data[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] limit_duty(longint v);
            if (v < 0) return 8'd0;
            if (v > DUTY_MAX) return 8'(DUTY_MAX);
            return v[7:0];
        endfunction

        function result_t pattern(logic [7:0] ra, logic [7:0] rb, logic [7:0] la,
                                  logic [7:0] lb, logic [2:0] st, logic [30:0] avg);
            result_t r;
            r.right_a_duty  = ra;
            r.right_b_duty  = rb;
            r.left_a_duty   = la;
            r.left_b_duty   = lb;
            r.status        = st;
            r.average_count = avg;
            return r;
        endfunction

        function result_t next_outputs(move_cmd_t c);
            longint      lmag, rmag, avg_l, fd, ld, rd, win, err, mag, adj;
            logic [30:0] avg;
            logic [31:0] held;
            logic [2:0]  end_st;
            logic [7:0]  brk;
            result_t     r;
            lmag = c.left_count;
            if (lmag < 0) lmag = -lmag;
            rmag = c.right_count;
            if (rmag < 0) rmag = -rmag;
            avg_l = (lmag + rmag) / 2;
            avg = (avg_l > longint'(AVG_LIMIT)) ? AVG_LIMIT : avg_l[30:0];
            fd = c.front_dist;
            ld = c.left_dist;
            rd = c.right_dist;
            win = longint'(wall_window);
            brk = 8'(DUTY_MAX);
            if (phase != PH_MOVING && phase != PH_BRAKING) phase = PH_IDLE;
            r = pattern(8'd0, 8'd0, 8'd0, 8'd0, ST_IDLE, avg);

            if (c.op == OP_START) begin
                if (phase == PH_IDLE) begin
                    phase = PH_MOVING;
                    prev_avg = '0;
                    last_motion_ms = c.now_ms;
                    r = pattern(8'd0, base_pwm, base_pwm, 8'd0, ST_MOVING, avg);
                end else if (phase == PH_MOVING) begin
                    r = pattern(8'd0, base_pwm, base_pwm, 8'd0, ST_MOVING, avg);
                end else begin
                    r = pattern(brk, brk, brk, brk, ST_BRAKING, avg);
                end
            end else if (phase == PH_BRAKING) begin
                held = c.now_ms - brake_start_ms;
                if (held >= BRAKE_HOLD_MS) phase = PH_IDLE;
                else r = pattern(brk, brk, brk, brk, ST_BRAKING, avg);
            end else if (phase == PH_MOVING) begin
                end_st = ST_MOVING;
                if (c.stop_request) begin
                    end_st = ST_STOPPED;
                end else begin
                    held = c.now_ms - last_motion_ms;
                    if ({1'b0, avg} > prev_avg) begin
                        last_motion_ms = c.now_ms;
                        prev_avg = {1'b0, avg};
                    end else if (held > {16'd0, stall_timeout_ms}) begin
                        end_st = ST_STALLED;
                    end
                    if (end_st == ST_MOVING && avg >= target_pulses) end_st = ST_REACHED;
                    if (end_st == ST_MOVING && fd > 0 && fd < longint'(bump_distance))
                        end_st = ST_OBSTACLE;
                end
                if (end_st != ST_MOVING) begin
                    phase = PH_BRAKING;
                    brake_start_ms = c.now_ms;
                    r = pattern(brk, brk, brk, brk, end_st, avg);
                end else if (!ignore_correction && ld > 0 && ld < win && rd > 0 && rd < win) begin
                    err = ld - rd;
                    mag = (err < 0 ? -err : err) * longint'(centering_gain) / 4096;
                    adj = (err < 0) ? -mag : mag;
                    r = pattern(8'd0, limit_duty(longint'(base_pwm) + adj),
                                limit_duty(longint'(base_pwm) - adj), 8'd0, ST_MOVING, avg);
                end else begin
                    r = pattern(8'd0, base_pwm, base_pwm, 8'd0, ST_MOVING, avg);
                end
            end
            return r;
        endfunction

        function void note_input(move_cmd_t c);
            pending_outputs.push_back(next_outputs(c));
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        task compare(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("output %0d %s: got %0d expected %0d",
                                 outputs_seen, field, got, want));
        endtask

        task check_output(result_t got);
            result_t want;
            outputs_seen++;
            if (pending_outputs.size() == 0) begin
                report($sformatf("output %0d arrived with nothing expected", outputs_seen));
                return;
            end
            want = pending_outputs.pop_front();
            compare("right_a_duty", got.right_a_duty, want.right_a_duty);
            compare("right_b_duty", got.right_b_duty, want.right_b_duty);
            compare("left_a_duty", got.left_a_duty, want.left_a_duty);
            compare("left_b_duty", got.left_b_duty, want.left_b_duty);
            compare("status", got.status, want.status);
            compare("average_count", got.average_count, want.average_count);
        endtask
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_op;
    logic [31:0]              s_now_ms;
    logic signed [31:0]       s_left_count;
    logic signed [31:0]       s_right_count;
    logic signed [DIST_W-1:0] s_front_dist;
    logic signed [DIST_W-1:0] s_left_dist;
    logic signed [DIST_W-1:0] s_right_dist;
    logic                     s_stop_request;
    logic                     m_valid;
    logic                     m_ready;
    logic [OUT_DUTY_W-1:0]    m_right_a_duty;
    logic [OUT_DUTY_W-1:0]    m_right_b_duty;
    logic [OUT_DUTY_W-1:0]    m_left_a_duty;
    logic [OUT_DUTY_W-1:0]    m_left_b_duty;
    logic [2:0]               m_status;
    logic [AVG_W-1:0]         m_average_count;

    move_scoreboard sb;
    logic [31:0]    sim_ms;
    bit             tx_burst;
    bit             rx_burst;
    int             items_sent;
    int             quiet_cycles = 0;

    encoder_distance_move_controller u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_now_ms        (s_now_ms),
        .s_left_count    (s_left_count),
        .s_right_count   (s_right_count),
        .s_front_dist    (s_front_dist),
        .s_left_dist     (s_left_dist),
        .s_right_dist    (s_right_dist),
        .s_stop_request  (s_stop_request),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_right_a_duty  (m_right_a_duty),
        .m_right_b_duty  (m_right_b_duty),
        .m_left_a_duty   (m_left_a_duty),
        .m_left_b_duty   (m_left_b_duty),
        .m_status        (m_status),
        .m_average_count (m_average_count)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Transfer monitor: inputs feed the predictor, results are checked in order.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_input(cmd(s_op, s_now_ms, s_left_count, s_right_count, s_front_dist,
                              s_left_dist, s_right_dist, s_stop_request));
        if (aresetn && m_valid && m_ready)
            sb.check_output(result_t'{m_right_a_duty, m_right_b_duty, m_left_a_duty,
                                      m_left_b_duty, m_status, m_average_count});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random hold-off before each transfer, none in burst stretches.
    initial begin
        int hold;
        m_ready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            hold = rx_burst ? 0 : $urandom_range(0, 9);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    function automatic move_cmd_t cmd(logic op, logic [31:0] now, logic signed [31:0] lc,
                                      logic signed [31:0] rc, logic signed [15:0] fd,
                                      logic signed [15:0] ld, logic signed [15:0] rd,
                                      logic stop);
        move_cmd_t c;
        c.op = op;
        c.now_ms = now;
        c.left_count = lc;
        c.right_count = rc;
        c.front_dist = fd;
        c.left_dist = ld;
        c.right_dist = rd;
        c.stop_request = stop;
        return c;
    endfunction

    function automatic logic signed [15:0] any_dist();
        logic [31:0] v;
        v = $urandom();
        return v[15:0];
    endfunction

    // -2^31 lies outside the count range
    function automatic logic signed [31:0] any_count();
        logic [31:0] v;
        v = $urandom();
        if (v == 32'h8000_0000) v = 32'h8000_0001;
        return v;
    endfunction

    function automatic logic signed [15:0] side_in_window();
        if (sb.wall_window >= 2) return 16'($urandom_range(1, sb.wall_window - 1));
        return 16'($urandom_range(1, 32767));
    endfunction

    function automatic logic signed [15:0] clear_front();
        if ($urandom_range(0, 3) == 0) return -16'($urandom_range(0, 32767));
        return 16'($urandom_range(sb.bump_distance, 32767));
    endfunction

    function automatic logic signed [15:0] near_front();
        if (sb.bump_distance >= 2) return 16'($urandom_range(1, sb.bump_distance - 1));
        return 16'sd1;
    endfunction

    // Caller sits at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so a back-to-back item needs no second assignment.
    task automatic send_cmd(move_cmd_t c);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op           <= c.op;
        s_now_ms       <= c.now_ms;
        s_left_count   <= c.left_count;
        s_right_count  <= c.right_count;
        s_front_dist   <= c.front_dist;
        s_left_dist    <= c.left_dist;
        s_right_dist   <= c.right_dist;
        s_stop_request <= c.stop_request;
        s_valid        <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_outputs.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic load_regs(logic [7:0] base, logic [30:0] target, logic [15:0] stall,
                             logic [14:0] bump, logic [14:0] window, logic [9:0] gain,
                             logic ignore);
        write_reg(REG_BASE_PWM, CFG_DATA_W'(base));
        write_reg(REG_TARGET_PULSES, CFG_DATA_W'(target));
        write_reg(REG_STALL_TIMEOUT, CFG_DATA_W'(stall));
        write_reg(REG_BUMP_DISTANCE, CFG_DATA_W'(bump));
        write_reg(REG_WALL_WINDOW, CFG_DATA_W'(window));
        write_reg(REG_CENTER_GAIN, CFG_DATA_W'(gain));
        write_reg(REG_IGNORE_CORR, CFG_DATA_W'(ignore));
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Reset values except base duty 128 and target 1000.
    task automatic directed();
        write_reg(REG_BASE_PWM, 31'd128);
        write_reg(REG_TARGET_PULSES, 31'd1000);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        send_cmd(cmd(OP_TICK, 32'd0, COUNT_MAX, -COUNT_MAX, 16'sh7FFF, 16'sh8000,
                     16'sh8000, 1'b1));
        send_cmd(cmd(OP_START, 32'd1000, 0, 0, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_START, 32'd1005, 0, 0, 16'sd0, 16'sd0, 16'sd0, 1'b1));
        send_cmd(cmd(OP_TICK, 32'd1010, 100, 100, 16'sh8000, 16'sd1000, 16'sd200, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd1020, 200, -200, 16'sd448, 16'sd1, 16'sd1919, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd1030, 300, 300, 16'sh7FFF, -16'sd1, 16'sd1000, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd1040, 350, 350, 16'sd0, 16'sh7FFF, 16'sh7FFF, 1'b0));
        // stop request, then the brake hold boundary
        send_cmd(cmd(OP_TICK, 32'd1050, 400, 400, 16'sd5000, 16'sd1000, 16'sd1000, 1'b1));
        send_cmd(cmd(OP_START, 32'd1060, 400, 400, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd1149, 400, 400, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd1150, 400, 400, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        // front obstacle one below the bump distance
        send_cmd(cmd(OP_START, 32'd5000, 0, 0, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd5010, 10, 10, 16'sd447, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd5110, 10, 10, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        // stall timer across the ms wrap: 300 holds, 301 aborts
        send_cmd(cmd(OP_START, 32'hFFFF_FFA0, 0, 0, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd204, 0, 0, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd205, 0, 0, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd305, 0, 0, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        // target reached exactly, negative counts
        send_cmd(cmd(OP_START, 32'd20000, 0, 0, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd20010, -1000, -1000, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd20110, -1000, -1000, 16'sd0, 16'sd0, 16'sd0, 1'b0));
        send_cmd(cmd(OP_TICK, 32'd20200, -COUNT_MAX, -COUNT_MAX, 16'sd0, 16'sd0,
                     16'sd0, 1'b0));
    endtask

    task automatic send_noise();
        send_cmd(cmd(1'($urandom_range(0, 1)), $urandom(), any_count(), any_count(),
                     any_dist(), any_dist(), any_dist(), 1'($urandom_range(0, 1))));
    endtask

    // One move: start, ticks until it ends (at most 40), then brake ticks until standby.
    task automatic run_move();
        longint    step_max, lmag, rmag;
        bit        lneg, rneg;
        int        k, ev;
        move_cmd_t c;
        step_max = longint'(sb.target_pulses) / 4 + 8;
        if (step_max > 400000000) step_max = 400000000;
        lmag = 0;
        rmag = 0;
        lneg = ($urandom_range(0, 3) == 0);
        rneg = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) sim_ms = $urandom();
        else sim_ms += $urandom_range(0, 50);
        send_cmd(cmd(OP_START, sim_ms, 0, 0, any_dist(), any_dist(), any_dist(),
                     $urandom_range(0, 7) == 0));
        k = 0;
        while (sb.phase == PH_MOVING && k < 40) begin
            ev = $urandom_range(0, 99);
            sim_ms += $urandom_range(0, 30);
            c = cmd(OP_TICK, 0, 0, 0, clear_front(), side_in_window(), side_in_window(), 1'b0);
            if (ev < 4) begin
                c.stop_request = 1'b1;
            end else if (ev < 10) begin
                sim_ms += sb.stall_timeout_ms + $urandom_range(0, 2);
            end else if (ev < 15) begin
                c.front_dist = near_front();
            end else begin
                lmag += $urandom_range(0, 32'(step_max));
                rmag += $urandom_range(0, 32'(step_max));
                if (lmag > COUNT_MAX) lmag = COUNT_MAX;
                if (rmag > COUNT_MAX) rmag = COUNT_MAX;
            end
            if (ev >= 85) begin
                c.left_dist = any_dist();
                c.right_dist = any_dist();
            end
            c.now_ms = sim_ms;
            c.left_count = lneg ? 32'(-lmag) : 32'(lmag);
            c.right_count = rneg ? 32'(-rmag) : 32'(rmag);
            send_cmd(c);
            k++;
        end
        while (sb.phase == PH_BRAKING) begin
            sim_ms += $urandom_range(0, 40);
            send_cmd(cmd(($urandom_range(0, 7) == 0) ? OP_START : OP_TICK, sim_ms,
                         lneg ? 32'(-lmag) : 32'(lmag), rneg ? 32'(-rmag) : 32'(rmag),
                         any_dist(), any_dist(), any_dist(), 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic random_phase(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0) begin
                send_noise();
            end else begin
                // hold the sender until every result is back
                if ($urandom_range(0, 7) == 0) drain();
                run_move();
            end
        end
    endtask

    initial begin
        int p;
        sb = new();
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_op           = OP_START;
        s_now_ms       = '0;
        s_left_count   = '0;
        s_right_count  = '0;
        s_front_dist   = '0;
        s_left_dist    = '0;
        s_right_dist   = '0;
        s_stop_request = 1'b0;
        sim_ms         = '0;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        items_sent     = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed();
        drain();
        load_regs(8'd255, 31'h7FFF_FFFF, 16'hFFFF, 15'd0, 15'h7FFF, 10'd1023, 1'b0);
        random_phase(110);
        drain();
        load_regs(8'd0, 31'd0, 16'd0, 15'h7FFF, 15'd0, 10'd0, 1'b1);
        random_phase(110);
        drain();
        load_regs(8'd128, 31'd3000, 16'd60, 15'd448, 15'd32767, 10'd1023, 1'b0);
        random_phase(100);
        for (p = 0; p < 5; p++) begin
            drain();
            load_regs(8'($urandom_range(0, 255)),
                      ($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 20000)),
                      16'($urandom_range(0, 500)), 15'($urandom_range(0, 1000)),
                      15'($urandom_range(0, 3000)), 10'($urandom_range(0, 1023)),
                      $urandom_range(0, 3) == 0);
            random_phase(105);
        end

        drain();
        repeat (10) @(negedge aclk);
        if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/edm_pkg.sv
sv/edm_prep.sv
sv/edm_ctrl.sv
sv/encoder_distance_move_controller.sv
sv/edm_checker.sv
tb/sv/tb_encoder_distance_move_controller.sv
